// ===== rtl/core/ntd_pkg.sv =====
package ntd_pkg;

    localparam int XW = 64;
    localparam int YSW = 16;
    localparam int YMW = 64;

    localparam logic [63:0] DBL_SIGN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DBL_QUIET  = 64'h0008_0000_0000_0000;
    localparam logic [10:0] DBL_EXPMAX = 11'h7ff;
    localparam logic [14:0] EXT_EXPMAX = 15'h7fff;

    // input word
    typedef struct packed {
        logic [63:0] x_bits;
        logic [15:0] y_sign_exp;
        logic [63:0] y_mantissa;
    } ntd_in_t;

    // result word
    typedef struct packed {
        logic [63:0] result_bits;
        logic        overflow_flag;
        logic        underflow_flag;
        logic        range_error;
    } ntd_out_t;

    // magnitude: class plus normalized significand and exponent
    typedef struct packed {
        logic        is_zero;
        logic        is_inf;
        logic [16:0] e;   // exponent offset so it stays nonnegative
        logic [63:0] m;
    } ntd_mag_t;

endpackage

// ===== rtl/core/ntd_if.sv =====
interface ntd_if #(parameter int W = 1) (input logic clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ntd_norm.sv =====
module ntd_norm (
    input  logic [63:0]  m_in,
    input  logic [16:0]  e_in,
    output logic [63:0]  m_out,
    output logic [16:0]  e_out,
    output logic         zero
);
    logic [6:0] lz;

    // leading zero count by priority scan over independent bits
    always_comb
    begin
        lz = 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (m_in[i])
            begin
                lz = 7'(63 - i);
            end
        end
    end

    assign zero  = (m_in == 64'd0);
    assign m_out = m_in << lz;
    assign e_out = e_in - {10'd0, lz};
endmodule

// ===== rtl/core/ntd_core.sv =====
module ntd_core (
    input  ntd_pkg::ntd_in_t  din,
    output ntd_pkg::ntd_out_t dout
);
    import ntd_pkg::*;

    logic        sx, sy;
    logic [10:0] ex;
    logic [51:0] fx;
    logic [14:0] ey;
    logic [63:0] xm_raw;
    logic [16:0] xe_raw, ye_raw;
    logic [63:0] xm, ym;
    logic [16:0] xe, ye;
    logic        xz, yz, xinf, yinf, xnan, ynan;
    logic        gt, eq;
    logic        x_gt_y;
    logic [63:0] res;
    logic [10:0] h;

    assign sx = din.x_bits[63];
    assign ex = din.x_bits[62:52];
    assign fx = din.x_bits[51:0];
    assign sy = din.y_sign_exp[15];
    assign ey = din.y_sign_exp[14:0];

    assign xnan = (ex == DBL_EXPMAX) && (fx != 52'd0);
    assign xinf = (ex == DBL_EXPMAX) && (fx == 52'd0);
    assign ynan = (ey == EXT_EXPMAX) && (din.y_mantissa[62:0] != 63'd0);
    assign yinf = (ey == EXT_EXPMAX) && (din.y_mantissa[62:0] == 63'd0);

    // exponents offset by 16446+64 so the scale is never negative
    always_comb
    begin
        if (ex == 11'd0)
        begin
            xm_raw = {12'd0, fx};
            xe_raw = 17'(16446 + 64 - 1074);
        end
        else
        begin
            xm_raw = {1'b1, fx, 11'd0};
            xe_raw = 17'({6'd0, ex} + 17'(16446 + 64 - 1086));
        end
        ye_raw = 17'(((ey == 15'd0) ? 17'd1 : {2'd0, ey}) + 17'd64);
    end

    ntd_norm u_nx (.m_in(xm_raw), .e_in(xe_raw), .m_out(xm), .e_out(xe), .zero(xz));
    ntd_norm u_ny (.m_in(din.y_mantissa), .e_in(ye_raw), .m_out(ym), .e_out(ye), .zero(yz));

    // magnitude compare
    always_comb
    begin
        if (xinf || yinf)
        begin
            eq = xinf && yinf;
            gt = xinf && !yinf;
        end
        else if (xz || yz)
        begin
            eq = xz && yz;
            gt = !xz && yz;
        end
        else
        begin
            eq = (xe == ye) && (xm == ym);
            gt = (xe > ye) || ((xe == ye) && (xm > ym));
        end
    end

    // an infinite y with a clear significand is not a zero y
    assign x_gt_y = ((yz && !yinf) || (sx != sy)) ? !sx : (gt != sx);
    assign h      = res[62:52];

    always_comb
    begin
        dout = '0;
        if (xnan)
        begin
            res = din.x_bits | DBL_QUIET;
        end
        else if (ynan)
        begin
            res = {sy, DBL_EXPMAX, din.y_mantissa[62:11]} | DBL_QUIET;
        end
        else if (xz && !xinf && yz && !yinf)
        begin
            res = {sy, 63'd0};
        end
        else if ((sx == sy) && eq)
        begin
            res = din.x_bits;
        end
        else if (xz && !xinf)
        begin
            res = {sy, 63'd1};
            dout.underflow_flag = 1'b1;
        end
        else
        begin
            res = (x_gt_y != sx) ? din.x_bits - 64'd1 : din.x_bits + 64'd1;
            if (h == DBL_EXPMAX)
            begin
                dout.overflow_flag = 1'b1;
            end
            else if (h == 11'd0)
            begin
                dout.underflow_flag = 1'b1;
            end
        end
        dout.result_bits = res;
        dout.range_error = dout.overflow_flag | dout.underflow_flag;
    end
endmodule

// ===== rtl/core/next_toward_double.sv =====
// an accepted input word passes the single input register, then the result register
// throughput: one word per cycle unless stalled, set by the two registers
// the output register drains while a new word enters; a stalled result holds
// rst_n asynchronously clears both valid bits; payload registers are not reset
module next_toward_double (
    input  logic   clk,
    input  logic   rst_n,
    ntd_if.sink    in_ch,
    ntd_if.source  out_ch
);
    import ntd_pkg::*;

    logic     in_vld_reg;
    ntd_in_t  in_reg;
    logic     out_vld_reg;
    ntd_out_t out_reg;
    ntd_out_t core_out;
    logic     adv;

    // stage moves when the result slot is free or being taken
    assign adv          = !out_vld_reg || out_ch.ready;
    assign in_ch.ready  = adv || !in_vld_reg;

    ntd_core u_core (.din(in_reg), .dout(core_out));

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_vld_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_reg <= ntd_in_t'(in_ch.data);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_vld_reg)
        begin
            out_reg <= core_out;
        end
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.data  = out_reg;
endmodule

// ===== rtl/core/ntd_check.sv =====
module ntd_check (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [66:0]  out_data
);
    // flag consistency on shown result
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data[0] == (out_data[1] | out_data[2])))
        else $error("range_error mismatch");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data[1] && out_data[2]))
        else $error("both flags set");

    // an accepted word must show up as a valid result when the output is open in between
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("result lost");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
endmodule

bind next_toward_double ntd_check u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import ntd_pkg::*;

    localparam int STALL_LEN = 40;

    logic clk;
    logic rst_n;

    ntd_if #(.W($bits(ntd_in_t)))  in_ch (.clk(clk));
    ntd_if #(.W($bits(ntd_out_t))) out_ch (.clk(clk));

    next_toward_double dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    ntd_in_t  pending_words[$];
    ntd_out_t neighbor_queue[$];
    int       mismatch_count;
    logic     stim_done;
    logic     hold_rx;
    logic     in_taken;

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // exact magnitude as normalized significand and exponent; class 0 zero, 1 finite, 2 inf
    typedef struct {
        int          cls;
        int          e;
        logic [63:0] m;
    } magnitude_t;

    function automatic magnitude_t norm_mag(logic [63:0] m, int e);
        magnitude_t v;
        v.cls = 0;
        v.e = 0;
        v.m = 0;
        if (m != 0)
        begin
            while (!m[63])
            begin
                m = m << 1;
                e = e - 1;
            end
            v.cls = 1;
            v.m = m;
            v.e = e;
        end
        return v;
    endfunction

    function automatic int compare_mag(magnitude_t a, magnitude_t b);
        if (a.cls != b.cls)
            return (a.cls > b.cls) ? 1 : -1;
        if (a.cls != 1)
            return 0;
        if (a.e != b.e)
            return (a.e > b.e) ? 1 : -1;
        if (a.m != b.m)
            return (a.m > b.m) ? 1 : -1;
        return 0;
    endfunction

    // neighbor of x toward y with range flags
    function automatic ntd_out_t step_toward(ntd_in_t w);
        ntd_out_t   r;
        logic       sx, sy, x_gt_y;
        logic [10:0] ex;
        logic [51:0] fx;
        logic [14:0] ey;
        logic [63:0] h;
        magnitude_t mx, my;
        int c;
        sx = w.x_bits[63];
        ex = w.x_bits[62:52];
        fx = w.x_bits[51:0];
        sy = w.y_sign_exp[15];
        ey = w.y_sign_exp[14:0];
        r = '0;
        if (ex == DBL_EXPMAX && fx != 0)
        begin
            r.result_bits = w.x_bits | DBL_QUIET;
            return r;
        end
        if (ey == EXT_EXPMAX && w.y_mantissa[62:0] != 0)
        begin
            r.result_bits = {sy, DBL_EXPMAX, w.y_mantissa[62:11]} | DBL_QUIET;
            return r;
        end
        if (ex == DBL_EXPMAX)
            mx = '{2, 0, 64'd0};
        else if (ex == 0)
            mx = norm_mag({12'd0, fx}, -1074);
        else
            mx = norm_mag({1'b1, fx, 11'd0}, int'(ex) - 1086);
        if (ey == EXT_EXPMAX)
            my = '{2, 0, 64'd0};
        else
            my = norm_mag(w.y_mantissa, ((ey == 0) ? 1 : int'(ey)) - 16446);
        if (mx.cls == 0 && my.cls == 0)
        begin
            r.result_bits = sy ? DBL_SIGN : 64'd0;
            return r;
        end
        c = compare_mag(mx, my);
        if (sx == sy && c == 0)
        begin
            r.result_bits = w.x_bits;
            return r;
        end
        if (mx.cls == 0)
        begin
            r.result_bits = {sy, 62'd0, 1'b1};
            r.underflow_flag = 1'b1;
            r.range_error = 1'b1;
            return r;
        end
        if (my.cls == 0 || sx != sy)
            x_gt_y = !sx;
        else
            x_gt_y = (c > 0) != sx;
        r.result_bits = (x_gt_y != sx) ? w.x_bits - 64'd1 : w.x_bits + 64'd1;
        h = r.result_bits & {1'b0, DBL_EXPMAX, 52'd0};
        if (h[62:52] == DBL_EXPMAX)
            r.overflow_flag = 1'b1;
        else if (h[62:52] == 0)
            r.underflow_flag = 1'b1;
        r.range_error = r.overflow_flag | r.underflow_flag;
        return r;
    endfunction

    // interesting doubles
    function automatic logic [63:0] pick_double();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = 64'h7ff0_0000_0000_0000;
            2: v = 64'h7fef_ffff_ffff_ffff;
            3: v = {12'd0, 20'd0, $urandom_range(0, 3)};
            4: v = 64'h0010_0000_0000_0000 + $urandom_range(0, 2) - 1;
            5: v = {1'b0, 11'h7ff, 52'({$urandom, $urandom})} | 64'h1;
            default: v = {$urandom, $urandom};
        endcase
        v[63] = $urandom_range(0, 1);
        return v;
    endfunction

    // y near x, in a random exponent range, a special encoding, or fully random
    function automatic ntd_in_t make_word();
        ntd_in_t w;
        logic [63:0] x;
        int e;
        x = pick_double();
        w.x_bits = x;
        w.y_sign_exp = 16'($urandom);
        w.y_mantissa = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1:
            begin
                // widen x exactly, then optionally nudge
                if (x[62:52] == 0)
                begin
                    w.y_sign_exp = {x[63], 15'd0};
                    w.y_mantissa = {12'd0, x[51:0]};
                    // scale to ext exponent 15361 with the explicit integer bit clear
                    e = 16383 - 1022;
                    w.y_sign_exp = {x[63], 15'(e)};
                    w.y_mantissa = {1'b0, x[51:0], 11'd0};
                end
                else if (x[62:52] == DBL_EXPMAX)
                begin
                    w.y_sign_exp = {x[63], EXT_EXPMAX};
                    w.y_mantissa = {$urandom_range(0, 1), 63'd0};
                end
                else
                begin
                    w.y_sign_exp = {x[63], 15'(int'(x[62:52]) - 1023 + 16383)};
                    w.y_mantissa = {1'b1, x[51:0], 11'd0};
                end
                if ($urandom_range(0, 2) == 0)
                    w.y_mantissa = w.y_mantissa + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 3) == 0)
                    w.y_sign_exp[15] = ~w.y_sign_exp[15];
            end
            2: w.y_sign_exp[14:0] = 15'(int'($urandom_range(15300, 17400)));
            3:
            begin
                w.y_sign_exp[14:0] = EXT_EXPMAX;
                if ($urandom_range(0, 1))
                    w.y_mantissa[62:0] = 0;
            end
            4: w.y_sign_exp[14:0] = 0;
            default: ;
        endcase
        return w;
    endfunction

    // stimulus
    initial
    begin
        logic [63:0] xs[6];
        stim_done = 1'b0;
        hold_rx = 1'b0;
        xs = '{64'd0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
               64'h7fef_ffff_ffff_ffff, 64'h0000_0000_0000_0001, 64'h3ff0_0000_0000_0000};
        // directed corners
        foreach (xs[i])
        begin
            pending_words.push_back('{xs[i], 16'h7fff, 64'h8000_0000_0000_0000});
            pending_words.push_back('{xs[i], 16'hffff, 64'h0});
            pending_words.push_back('{xs[i], 16'h0000, 64'h0});
            pending_words.push_back('{xs[i], 16'h8000, 64'h0});
        end
        pending_words.push_back('{64'h7ff0_0000_0000_0001, 16'h3fff, 64'h8000_0000_0000_0000});
        pending_words.push_back('{64'h3ff0_0000_0000_0000, 16'h7fff, 64'hc000_0000_0000_0800});
        pending_words.push_back('{64'h3ff0_0000_0000_0000, 16'h3fff, 64'h8000_0000_0000_0000});
        pending_words.push_back('{64'hffff_ffff_ffff_ffff, 16'hffff, 64'hffff_ffff_ffff_ffff});
        wait (rst_n);
        // long receiver stall while the sender keeps offering
        @(negedge clk);
        hold_rx = 1'b1;
        for (int i = 0; i < 900; i++)
            pending_words.push_back(make_word());
        repeat (STALL_LEN) @(posedge clk);
        @(negedge clk);
        hold_rx = 1'b0;
        // pause the sender until everything drains
        wait (pending_words.size() == 0 && neighbor_queue.size() == 0);
        for (int i = 0; i < 900; i++)
            pending_words.push_back(make_word());
        wait (pending_words.size() == 0);
        stim_done = 1'b1;
    end

    // remember whether the offered word was taken at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= in_ch.valid && in_ch.ready;
    end

    // driver
    int send_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            send_gap <= 0;
        end
        else if (in_ch.valid && !in_taken)
        begin
        end
        else if (send_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_words.size() > 0)
        begin
            in_ch.valid <= 1'b1;
            in_ch.data <= pending_words.pop_front();
            send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 3);
        end
        else
            in_ch.valid <= 1'b0;
    end

    // predict on input acceptance
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            neighbor_queue.push_back(step_toward(ntd_in_t'(in_ch.data)));
    end

    // receiver ready with random stalls
    int recv_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else if (hold_rx)
            out_ch.ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (out_ch.valid)
                recv_gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        ntd_out_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = ntd_out_t'(out_ch.data);
            if (neighbor_queue.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                want = neighbor_queue.pop_front();
                if (got.result_bits !== want.result_bits
                    || got.overflow_flag !== want.overflow_flag
                    || got.underflow_flag !== want.underflow_flag
                    || got.range_error !== want.range_error)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h %b%b%b got %h %b%b%b",
                            want.result_bits, want.overflow_flag, want.underflow_flag,
                            want.range_error, got.result_bits, got.overflow_flag,
                            got.underflow_flag, got.range_error);
                end
            end
        end
    end

    // end of run
    initial
    begin
        mismatch_count = 0;
        wait (rst_n);
        wait (stim_done);
        wait (neighbor_queue.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && neighbor_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ntd_pkg.sv
rtl/core/ntd_if.sv
rtl/core/ntd_norm.sv
rtl/core/ntd_core.sv
rtl/core/next_toward_double.sv
rtl/core/ntd_check.sv
tb/testbench.sv
